// File: hw/rtl/dual_load_safety_supervisor_top_defines.svh
// ----------------------------------------------------------------------------
// Dual load safety supervisor assertion macros
// Shared concurrent assertion forms, clocked on i_clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef DUAL_LOAD_SAFETY_SUPERVISOR_TOP_DEFINES_SVH
`define DUAL_LOAD_SAFETY_SUPERVISOR_TOP_DEFINES_SVH

// same-cycle implication
`define DLSS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define DLSS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/dlss_pkg.sv
// ----------------------------------------------------------------------------
// Dual load safety supervisor package
// Widths, register indexes, reset values, codes and payload types.
// ----------------------------------------------------------------------------
package dlss_pkg;

    localparam int LOAD_W     = 16;
    localparam int TIME_W     = 32;
    localparam int OVL_W      = 15;
    localparam int RATIO_W    = 8;
    localparam int FLOOR_W    = 15;
    localparam int RATE_W     = 16;
    localparam int MODE_W     = 2;
    localparam int REASON_W   = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int MS_PER_S   = 1000;

    localparam logic [CFG_IDX_W-1:0] CFG_OVERLOAD_LIMIT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MISMATCH_RATIO  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MISMATCH_FLOOR  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DROP_RATE_LIMIT = 3'd3;

    localparam logic [OVL_W-1:0]   RST_OVERLOAD_LIMIT  = 15'd12800;
    localparam logic [RATIO_W-1:0] RST_MISMATCH_RATIO  = 8'd51;
    localparam logic [FLOOR_W-1:0] RST_MISMATCH_FLOOR  = 15'd256;
    localparam logic [RATE_W-1:0]  RST_DROP_RATE_LIMIT = 16'd2560;

    localparam logic [MODE_W-1:0] MODE_NORMAL   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FAILSAFE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DESCENT  = 2'd2;

    localparam logic [REASON_W-1:0] WHY_OK       = 3'd0;
    localparam logic [REASON_W-1:0] WHY_LINK     = 3'd1;
    localparam logic [REASON_W-1:0] WHY_MISMATCH = 3'd2;
    localparam logic [REASON_W-1:0] WHY_OVERLOAD = 3'd3;
    localparam logic [REASON_W-1:0] WHY_DROP     = 3'd4;

    typedef struct packed {
        logic signed [LOAD_W-1:0] primary_left_load;
        logic signed [LOAD_W-1:0] primary_right_load;
        logic signed [LOAD_W-1:0] secondary_left_load;
        logic signed [LOAD_W-1:0] secondary_right_load;
        logic [TIME_W-1:0]        sample_time_ms;
        logic                     secondary_ok;
    } t_sample_in;

    typedef struct packed {
        logic [MODE_W-1:0]   system_mode;
        logic [REASON_W-1:0] fault_reason;
        logic                release_locked;
        logic                descent_enabled;
    } t_sample_out;

endpackage

// File: hw/rtl/dual_load_safety_supervisor_top.sv
// ----------------------------------------------------------------------------
// Dual load safety supervisor
// Registered: each sample passes the input register, the check logic and the
// result register. Throughput: one sample per cycle unless the output stalls.
// Synchronous reset restores register defaults, clears the stored sample,
// locks the release and clears descent.
// ----------------------------------------------------------------------------
module dual_load_safety_supervisor_top
    import dlss_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_sample_in            i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_sample_out           o_out_data,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int DEN_W = (LOAD_W > FLOOR_W) ? LOAD_W : FLOOR_W;
    localparam int MM_W  = (LOAD_W + 9 > DEN_W + RATIO_W) ? LOAD_W + 9 : DEN_W + RATIO_W;
    localparam int OVC_W = ((LOAD_W > OVL_W) ? LOAD_W : OVL_W) + 1;
    localparam int RT_W  = RATE_W + TIME_W;
    localparam int DRP_W = ((LOAD_W + 11 > RT_W) ? LOAD_W + 11 : RT_W) + 1;

    function automatic logic side_mismatch(
        input logic signed [LOAD_W-1:0] a,
        input logic signed [LOAD_W-1:0] b,
        input logic [RATIO_W-1:0]       ratio,
        input logic [FLOOR_W-1:0]       floor_v
    );
        logic signed [LOAD_W:0] diff;
        logic [LOAD_W:0]        mag_d;
        logic [LOAD_W-1:0]      mag_a;
        logic [LOAD_W-1:0]      mag_b;
        logic [DEN_W-1:0]       den;
        logic [MM_W-1:0]        lhs;
        logic [MM_W-1:0]        rhs;
        diff  = (LOAD_W+1)'(a) - (LOAD_W+1)'(b);
        mag_d = diff[LOAD_W] ? (LOAD_W+1)'(-diff) : (LOAD_W+1)'(diff);
        mag_a = a[LOAD_W-1] ? LOAD_W'(-a) : LOAD_W'(a);
        mag_b = b[LOAD_W-1] ? LOAD_W'(-b) : LOAD_W'(b);
        den   = DEN_W'(mag_a);
        if (mag_b > mag_a) begin
            den = DEN_W'(mag_b);
        end
        if (den < DEN_W'(floor_v)) begin
            den = DEN_W'(floor_v);
        end
        lhs = MM_W'({mag_d, 8'b0});
        rhs = MM_W'(ratio) * MM_W'(den);
        return lhs > rhs;
    endfunction

    function automatic logic side_drop(
        input logic signed [LOAD_W-1:0] prev,
        input logic signed [LOAD_W-1:0] cur,
        input logic [RT_W-1:0]          rate_dt
    );
        logic signed [LOAD_W:0]  fall;
        logic signed [DRP_W-1:0] lhs;
        logic signed [DRP_W-1:0] rhs;
        fall = (LOAD_W+1)'(prev) - (LOAD_W+1)'(cur);
        lhs  = DRP_W'(fall) * DRP_W'(MS_PER_S);
        rhs  = DRP_W'($signed({1'b0, rate_dt}));
        return lhs > rhs;
    endfunction

    logic [OVL_W-1:0]          r_ovl;
    logic [RATIO_W-1:0]        r_ratio;
    logic [FLOOR_W-1:0]        r_floor;
    logic [RATE_W-1:0]         r_rate;
    logic signed [LOAD_W-1:0]  r_prev_left;
    logic signed [LOAD_W-1:0]  r_prev_right;
    logic [TIME_W-1:0]         r_prev_time;
    logic                      r_lock;
    logic                      r_descent;
    logic                      r_in_valid;
    t_sample_in                r_in;
    logic                      r_out_valid;
    t_sample_out               r_out;

    logic                      w_out_free;
    logic                      w_advance;
    logic                      w_accept;
    logic                      w_cfg_we;
    logic [TIME_W-1:0]         w_dt;
    logic [RT_W-1:0]           w_rate_dt;
    logic signed [OVC_W-1:0]   w_ovl_lim;
    logic                      w_mismatch;
    logic                      w_overload;
    logic                      w_drop;
    logic [MODE_W-1:0]         w_mode;
    logic [REASON_W-1:0]       w_reason;
    logic                      n_lock;
    logic                      n_descent;

    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_advance   = r_in_valid && w_out_free;
    assign o_in_stall  = r_in_valid && !w_out_free;
    assign w_accept    = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;
    assign w_cfg_we    = i_cfg_valid && o_cfg_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign w_dt      = r_in.sample_time_ms - r_prev_time;
    assign w_rate_dt = RT_W'(r_rate) * RT_W'(w_dt);
    assign w_ovl_lim = OVC_W'($signed({1'b0, r_ovl}));

    always_comb begin
        w_mismatch = side_mismatch(r_in.primary_left_load, r_in.secondary_left_load,
                                   r_ratio, r_floor)
                  || side_mismatch(r_in.primary_right_load, r_in.secondary_right_load,
                                   r_ratio, r_floor);
        w_overload = (OVC_W'(r_in.primary_left_load) > w_ovl_lim)
                  || (OVC_W'(r_in.primary_right_load) > w_ovl_lim);
        w_drop     = (w_dt != '0)
                  && (side_drop(r_prev_left, r_in.primary_left_load, w_rate_dt)
                  ||  side_drop(r_prev_right, r_in.primary_right_load, w_rate_dt));
    end

    always_comb begin
        priority if (!r_in.secondary_ok) begin
            w_mode   = MODE_FAILSAFE;
            w_reason = WHY_LINK;
        end else if (w_mismatch) begin
            w_mode   = MODE_FAILSAFE;
            w_reason = WHY_MISMATCH;
        end else if (w_overload) begin
            w_mode   = MODE_FAILSAFE;
            w_reason = WHY_OVERLOAD;
        end else if (w_drop) begin
            w_mode   = MODE_DESCENT;
            w_reason = WHY_DROP;
        end else begin
            w_mode   = MODE_NORMAL;
            w_reason = WHY_OK;
        end
        n_lock    = r_lock && (w_reason == WHY_OK);
        n_descent = r_descent || (w_reason == WHY_DROP);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovl        <= RST_OVERLOAD_LIMIT;
            r_ratio      <= RST_MISMATCH_RATIO;
            r_floor      <= RST_MISMATCH_FLOOR;
            r_rate       <= RST_DROP_RATE_LIMIT;
            r_prev_left  <= '0;
            r_prev_right <= '0;
            r_prev_time  <= '0;
            r_lock       <= 1'b1;
            r_descent    <= 1'b0;
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (w_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_OVERLOAD_LIMIT:  r_ovl   <= i_cfg_data[OVL_W-1:0];
                    CFG_MISMATCH_RATIO:  r_ratio <= i_cfg_data[RATIO_W-1:0];
                    CFG_MISMATCH_FLOOR:  r_floor <= i_cfg_data[FLOOR_W-1:0];
                    CFG_DROP_RATE_LIMIT: r_rate  <= i_cfg_data[RATE_W-1:0];
                    default: ;
                endcase
            end
            if (w_advance) begin
                r_lock    <= n_lock;
                r_descent <= n_descent;
                if (w_reason == WHY_OK) begin
                    r_prev_left  <= r_in.primary_left_load;
                    r_prev_right <= r_in.primary_right_load;
                    r_prev_time  <= r_in.sample_time_ms;
                end
            end
            if (w_accept) begin
                r_in_valid <= 1'b1;
            end else if (w_advance) begin
                r_in_valid <= 1'b0;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in <= i_in_data;
        end
        if (w_advance) begin
            r_out.system_mode     <= w_mode;
            r_out.fault_reason    <= w_reason;
            r_out.release_locked  <= n_lock;
            r_out.descent_enabled <= n_descent;
        end
    end

endmodule

// File: hw/rtl/dlss_checker.sv
// ----------------------------------------------------------------------------
// Dual load safety supervisor checker
// Port-level checks of result consistency and latch behavior, bound to top.
// ----------------------------------------------------------------------------
`include "dual_load_safety_supervisor_top_defines.svh"

module dlss_props
    import dlss_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input t_sample_out o_out_data
);

    logic r_seen_unlock;
    logic r_seen_descent;
    logic w_xfer;
    logic w_hold;
    logic w_after_unlock;
    logic w_after_descent;
    logic w_fault;
    logic w_fault_shown;

    assign w_xfer          = o_out_valid && !i_out_stall;
    assign w_hold          = o_out_valid && i_out_stall;
    assign w_after_unlock  = o_out_valid && r_seen_unlock;
    assign w_after_descent = o_out_valid && r_seen_descent;
    assign w_fault         = o_out_valid && (o_out_data.fault_reason != WHY_OK);
    assign w_fault_shown   = !o_out_data.release_locked
                          && (o_out_data.system_mode != MODE_NORMAL);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_unlock  <= 1'b0;
            r_seen_descent <= 1'b0;
        end else if (w_xfer) begin
            if (!o_out_data.release_locked) begin
                r_seen_unlock <= 1'b1;
            end
            if (o_out_data.descent_enabled) begin
                r_seen_descent <= 1'b1;
            end
        end
    end

    `DLSS_ASSERT_NEXT(a_out_hold, w_hold, o_out_valid && $stable(o_out_data), "stall hold broken")
    `DLSS_ASSERT_NOW(a_lock_sticky, w_after_unlock, !o_out_data.release_locked, "release relocked")
    `DLSS_ASSERT_NOW(a_desc_sticky, w_after_descent, o_out_data.descent_enabled, "descent dropped")
    `DLSS_ASSERT_NOW(a_fault_unlocks, w_fault, w_fault_shown, "fault without unlock")

endmodule

bind dual_load_safety_supervisor_top dlss_props u_dlss_props (.*);

// File: tb/dlss_checker.sv
// ----------------------------------------------------------------------------
// Dual load safety supervisor result checker
// Watches the sample, result and register channels. Keeps its own copy of
// the limits and the stored sample, predicts the verdict for every sample
// transfer and compares each result transfer field by field, oldest first.
// ----------------------------------------------------------------------------
module dlss_checker
    import dlss_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_stall,
    input  t_sample_in            i_in_data,
    input  logic                  i_out_valid,
    input  logic                  i_out_stall,
    input  t_sample_out           i_out_data,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_fail_count,
    output int                    o_pending,
    output int                    o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [OVL_W-1:0]   ovl_limit;
    logic [RATIO_W-1:0] ratio_q;
    logic [FLOOR_W-1:0] floor_kg;
    logic [RATE_W-1:0]  rate_limit;

    longint            last_left;
    longint            last_right;
    logic [TIME_W-1:0] last_time;
    logic              lock_q;
    logic              descent_q;

    t_sample_out expected_verdicts[$];

    function automatic longint abs_kg(longint x);
        return (x < 0) ? -x : x;
    endfunction

    function automatic logic side_mismatch(longint a, longint b);
        longint denom;
        denom = abs_kg(a);
        if (abs_kg(b) > denom) begin
            denom = abs_kg(b);
        end
        if (denom < longint'(floor_kg)) begin
            denom = longint'(floor_kg);
        end
        return abs_kg(a - b) * 256 > longint'(ratio_q) * denom;
    endfunction

    function automatic logic side_drop(longint prev, longint cur, logic [TIME_W-1:0] dt);
        return (prev - cur) * MS_PER_S > longint'(rate_limit) * longint'(dt);
    endfunction

    // verdict for one sample; updates the stored sample and the latches
    function automatic t_sample_out judge_sample(t_sample_in s);
        longint            pl;
        longint            pr;
        longint            sl;
        longint            sr;
        logic [TIME_W-1:0] dt;
        t_sample_out       v;
        pl = longint'($signed(s.primary_left_load));
        pr = longint'($signed(s.primary_right_load));
        sl = longint'($signed(s.secondary_left_load));
        sr = longint'($signed(s.secondary_right_load));
        dt = s.sample_time_ms - last_time;
        v.system_mode  = MODE_NORMAL;
        v.fault_reason = WHY_OK;
        if (!s.secondary_ok) begin
            v.system_mode  = MODE_FAILSAFE;
            v.fault_reason = WHY_LINK;
        end else if (side_mismatch(pl, sl) || side_mismatch(pr, sr)) begin
            v.system_mode  = MODE_FAILSAFE;
            v.fault_reason = WHY_MISMATCH;
        end else if (pl > longint'(ovl_limit) || pr > longint'(ovl_limit)) begin
            v.system_mode  = MODE_FAILSAFE;
            v.fault_reason = WHY_OVERLOAD;
        end else if (dt != '0 && (side_drop(last_left, pl, dt) ||
                                  side_drop(last_right, pr, dt))) begin
            v.system_mode  = MODE_DESCENT;
            v.fault_reason = WHY_DROP;
        end
        if (v.fault_reason == WHY_OK) begin
            last_left  = pl;
            last_right = pr;
            last_time  = s.sample_time_ms;
        end else begin
            lock_q = 1'b0;
            if (v.fault_reason == WHY_DROP) begin
                descent_q = 1'b1;
            end
        end
        v.release_locked  = lock_q;
        v.descent_enabled = descent_q;
        return v;
    endfunction

    task automatic flag_error(string msg);
        o_fail_count++;
        if (o_fail_count <= 10) begin
            $display("%0t ERROR: %s", $realtime, msg);
        end
    endtask

    always @(posedge i_clk) begin : track
        t_sample_out want;
        if (!i_rst_n) begin
            ovl_limit    = RST_OVERLOAD_LIMIT;
            ratio_q      = RST_MISMATCH_RATIO;
            floor_kg     = RST_MISMATCH_FLOOR;
            rate_limit   = RST_DROP_RATE_LIMIT;
            last_left    = 0;
            last_right   = 0;
            last_time    = '0;
            lock_q       = 1'b1;
            descent_q    = 1'b0;
            o_fail_count = 0;
            o_checked    = 0;
            expected_verdicts.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_OVERLOAD_LIMIT:  ovl_limit  = i_cfg_data[OVL_W-1:0];
                    CFG_MISMATCH_RATIO:  ratio_q    = i_cfg_data[RATIO_W-1:0];
                    CFG_MISMATCH_FLOOR:  floor_kg   = i_cfg_data[FLOOR_W-1:0];
                    CFG_DROP_RATE_LIMIT: rate_limit = i_cfg_data[RATE_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                expected_verdicts.push_back(judge_sample(i_in_data));
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_verdicts.size() == 0) begin
                    flag_error($sformatf("result transfer with nothing pending: %p",
                                         i_out_data));
                end else begin
                    want = expected_verdicts.pop_front();
                    o_checked++;
                    if (i_out_data.system_mode     !== want.system_mode  ||
                        i_out_data.fault_reason    !== want.fault_reason ||
                        i_out_data.release_locked  !== want.release_locked ||
                        i_out_data.descent_enabled !== want.descent_enabled) begin
                        flag_error($sformatf({"result %0d: expected mode %0d reason %0d ",
                            "lock %0b descent %0b, got mode %0d reason %0d lock %0b ",
                            "descent %0b"}, o_checked,
                            want.system_mode, want.fault_reason,
                            want.release_locked, want.descent_enabled,
                            i_out_data.system_mode, i_out_data.fault_reason,
                            i_out_data.release_locked, i_out_data.descent_enabled));
                    end
                end
            end
        end
        o_pending = expected_verdicts.size();
    end

endmodule

// File: tb/dual_load_safety_supervisor_top_test.sv
// ----------------------------------------------------------------------------
// Dual load safety supervisor testbench
// Directed corner samples, then mostly well-formed random sample streams
// with noise, across several limit settings including both extremes, with
// random gaps and output stalls and one long output hold-off.
// ----------------------------------------------------------------------------
module dual_load_safety_supervisor_top_test
    import dlss_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PHASE_COUNT     = 6;
    localparam int ITEMS_PER_PHASE = 310;
    localparam int HOLD_CYCLES     = 250;
    localparam int SETTLE_CYCLES   = 6;
    localparam int CYCLE_LIMIT     = 400000;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    t_sample_in            in_data;
    logic                  out_valid;
    logic                  out_stall;
    t_sample_out           out_data;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int fail_count;
    int pending;
    int checked;
    int cycle_count = 0;
    int samples_sent = 0;

    logic              idle_on;
    logic              hold_req;
    logic [TIME_W-1:0] stim_time;
    int                stim_left;
    int                stim_right;

    dual_load_safety_supervisor_top uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    dlss_checker u_verdict_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_data   (out_data),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending", cycle_count, pending);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic logic [LOAD_W-1:0] clamp_load(int v);
        if (v > 32767) begin
            return 16'sd32767;
        end
        if (v < -32768) begin
            return 16'h8000;
        end
        return LOAD_W'(v);
    endfunction

    function automatic t_sample_in build_sample(int pl, int pr, int sl, int sr,
                                                logic [TIME_W-1:0] t, logic ok);
        t_sample_in s;
        s.primary_left_load    = clamp_load(pl);
        s.primary_right_load   = clamp_load(pr);
        s.secondary_left_load  = clamp_load(sl);
        s.secondary_right_load = clamp_load(sr);
        s.sample_time_ms       = t;
        s.secondary_ok         = ok;
        return s;
    endfunction

    // mostly plausible load traces with matching mirrors; some pure noise
    function automatic t_sample_in make_sample();
        int pick;
        int l;
        int r;
        int dl;
        int dr;
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
            return build_sample(int'($signed(16'($urandom))), int'($signed(16'($urandom))),
                                int'($signed(16'($urandom))), int'($signed(16'($urandom))),
                                $urandom, 1'($urandom));
        end
        l = stim_left + $urandom_range(0, 600) - 300;
        r = stim_right + $urandom_range(0, 600) - 300;
        if (pick < 22) begin
            l = stim_left - $urandom_range(300, 9000);
        end else if (pick < 34) begin
            r = stim_right - $urandom_range(300, 9000);
        end
        if (l > 15000 || l < -2000) begin
            l = $urandom_range(0, 12000);
        end
        if (r > 15000 || r < -2000) begin
            r = $urandom_range(0, 12000);
        end
        stim_left  = l;
        stim_right = r;
        if ($urandom_range(0, 14) != 0) begin
            stim_time = stim_time + $urandom_range(1, 120);
        end
        dl = $urandom_range(0, 1) ? 0 : $urandom_range(0, 60) - 30;
        dr = $urandom_range(0, 1) ? 0 : $urandom_range(0, 60) - 30;
        if ($urandom_range(0, 19) == 0) begin
            dl = $urandom_range(0, 4000) - 2000;
        end
        return build_sample(l, r, l + dl, r + dr, stim_time, $urandom_range(0, 24) != 0);
    endfunction

    task automatic send_sample(t_sample_in s);
        int gap;
        gap = idle_on ? $urandom_range(0, 10) : 0;
        @(negedge clk);
        if (gap > 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid = 1'b1;
        in_data  = s;
        do @(posedge clk); while (in_stall);
        samples_sent++;
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // stop offering samples until every result is back
    task automatic settle();
        @(negedge clk);
        in_valid = 1'b0;
        do @(negedge clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    initial begin : receiver
        int   n;
        logic held;
        out_stall = 1'b0;
        held      = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_req && !held) begin
                out_stall = 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                held      = 1'b1;
                out_stall = 1'b0;
            end else begin
                n = idle_on ? $urandom_range(0, 10) : 0;
                if (n > 0) begin
                    out_stall = 1'b1;
                    repeat (n) @(negedge clk);
                end
                out_stall = 1'b0;
                do @(posedge clk); while (!out_valid);
            end
        end
    end

    initial begin : stimulus
        idle_on    = 1'b1;
        hold_req   = 1'b0;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_data    = '0;
        cfg_valid  = 1'b0;
        cfg_index  = CFG_OVERLOAD_LIMIT;
        cfg_data   = '0;
        stim_left  = 0;
        stim_right = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // corner samples at the reset limits
        send_sample(build_sample(0, 0, 0, 0, 50, 1'b1));
        send_sample(build_sample(32767, -32768, -32768, 32767, 60, 1'b0));
        send_sample(build_sample(1000, 0, 0, 0, 70, 1'b1));
        send_sample(build_sample(0, -1000, 0, 1000, 80, 1'b1));
        send_sample(build_sample(60, 0, 0, 0, 90, 1'b1));
        send_sample(build_sample(10, 0, 0, 0, 100, 1'b1));
        send_sample(build_sample(12801, 12801, 12801, 12801, 110, 1'b1));
        send_sample(build_sample(12800, 12800, 12800, 12800, 150, 1'b1));
        send_sample(build_sample(12800, 0, 12800, 0, 200, 1'b1));
        send_sample(build_sample(12800, 12700, 12800, 12700, 150, 1'b1));
        send_sample(build_sample(0, 0, 0, 0, 100, 1'b1));
        send_sample(build_sample(-32768, -32768, -32768, -32768, 101, 1'b1));
        send_sample(build_sample(32767, 32767, 32767, 32767, 102, 1'b1));
        send_sample(build_sample(2560, 2560, 2560, 2560, 1100, 1'b1));
        send_sample(build_sample(0, 0, 0, 0, 2100, 1'b1));
        send_sample(build_sample(256, 0, 205, 0, 2150, 1'b1));
        send_sample(build_sample(-256, 300, -205, 300, 2200, 1'b1));
        stim_time = 2200;

        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            settle();
            case (phase)
                1: begin
                    // oversized data, upper bits must be dropped
                    write_reg(CFG_OVERLOAD_LIMIT, 16'hFFFF);
                    write_reg(CFG_MISMATCH_RATIO, 16'hFFFF);
                    write_reg(CFG_MISMATCH_FLOOR, 16'hFFFF);
                    write_reg(CFG_DROP_RATE_LIMIT, 16'hFFFF);
                    for (int k = CFG_DROP_RATE_LIMIT + 1; k < 2 ** CFG_IDX_W; k++) begin
                        write_reg(CFG_IDX_W'(k), 16'($urandom));
                    end
                end
                2: begin
                    write_reg(CFG_OVERLOAD_LIMIT, '0);
                    write_reg(CFG_MISMATCH_RATIO, '0);
                    write_reg(CFG_MISMATCH_FLOOR, '0);
                    write_reg(CFG_DROP_RATE_LIMIT, '0);
                end
                3, 4: begin
                    write_reg(CFG_OVERLOAD_LIMIT, 16'($urandom_range(6000, 20000)));
                    write_reg(CFG_MISMATCH_RATIO, 16'($urandom_range(10, 120)));
                    write_reg(CFG_MISMATCH_FLOOR, 16'($urandom_range(0, 1000)));
                    write_reg(CFG_DROP_RATE_LIMIT, 16'($urandom_range(0, 8000)));
                end
                5: begin
                    write_reg(CFG_OVERLOAD_LIMIT, 16'(RST_OVERLOAD_LIMIT));
                    write_reg(CFG_MISMATCH_RATIO, 16'(RST_MISMATCH_RATIO));
                    write_reg(CFG_MISMATCH_FLOOR, 16'(RST_MISMATCH_FLOOR));
                    write_reg(CFG_DROP_RATE_LIMIT, RST_DROP_RATE_LIMIT);
                end
                default: ;
            endcase
            idle_on  = (phase != 4);
            hold_req = (phase == 5);
            repeat (ITEMS_PER_PHASE) send_sample(make_sample());
        end
        settle();

        $display("%0d results checked for %0d samples over %0d limit settings", checked,
                 samples_sent, PHASE_COUNT);
        $display("covered link, mismatch, overload and drop faults, latch holds, time wrap");
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
